@@ hdl/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// modexp_pkg: constants, control word and microprogram for the modular
// exponentiation core.
// Holds the prime, the Barrett reciprocal, the correction multiples and the
// read-only table of control words that the sequencer steps through.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int EXP_BITS_DEF = 63;

	localparam logic [63:0] PRIME_W = 64'd1000000007;
	localparam logic [31:0] PRIME = PRIME_W[31:0];
	localparam logic [63:0] R32_W = (64'd1 << 32) % PRIME_W;
	localparam logic [31:0] R32 = R32_W[31:0];
	localparam logic [63:0] BARRETT_M_W = (64'd1 << 61) / PRIME_W;
	localparam logic [31:0] BARRETT_M = BARRETT_M_W[31:0];

	localparam logic [32:0] PRIME_X1 = 33'(PRIME_W);
	localparam logic [32:0] PRIME_X2 = 33'(PRIME_W * 64'd2);
	localparam logic [32:0] PRIME_X3 = 33'(PRIME_W * 64'd3);
	localparam logic [32:0] PRIME_X4 = 33'(PRIME_W * 64'd4);
	localparam logic [32:0] PRIME_X5 = 33'(PRIME_W * 64'd5);
	localparam logic [32:0] PRIME_X6 = 33'(PRIME_W * 64'd6);

	localparam int PC_W = 5;

	localparam logic [PC_W-1:0] PC_WAIT     = 5'd0;
	localparam logic [PC_W-1:0] PC_BASE_MUL = 5'd1;
	localparam logic [PC_W-1:0] PC_BASE_EST = 5'd2;
	localparam logic [PC_W-1:0] PC_BASE_QP  = 5'd3;
	localparam logic [PC_W-1:0] PC_BASE_SUB = 5'd4;
	localparam logic [PC_W-1:0] PC_BASE_FIX = 5'd5;
	localparam logic [PC_W-1:0] PC_SQ_MUL   = 5'd6;
	localparam logic [PC_W-1:0] PC_SQ_EST   = 5'd7;
	localparam logic [PC_W-1:0] PC_SQ_QP    = 5'd8;
	localparam logic [PC_W-1:0] PC_SQ_SUB   = 5'd9;
	localparam logic [PC_W-1:0] PC_SQ_FIX   = 5'd10;
	localparam logic [PC_W-1:0] PC_MB_MUL   = 5'd11;
	localparam logic [PC_W-1:0] PC_MB_EST   = 5'd12;
	localparam logic [PC_W-1:0] PC_MB_QP    = 5'd13;
	localparam logic [PC_W-1:0] PC_MB_SUB   = 5'd14;
	localparam logic [PC_W-1:0] PC_MB_FIX   = 5'd15;
	localparam logic [PC_W-1:0] PC_NEXT     = 5'd16;
	localparam logic [PC_W-1:0] PC_FINAL    = 5'd17;

	typedef enum logic [2:0] {
		OP_BASE_HI,
		OP_SQUARE,
		OP_MUL_BASE,
		OP_ESTIMATE,
		OP_QUOT
	} opsel_t;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_INPUT,
		JC_BIT_CLEAR,
		JC_MORE_BITS,
		JC_OUT_FREE
	} jcond_t;

	typedef enum logic {
		DST_BASE,
		DST_ACC
	} dst_t;

	typedef struct packed {
		logic            mul_en;
		opsel_t          op;
		logic            x_en;
		logic            add_lo;
		logic            sub_en;
		logic            fix_en;
		dst_t            dst;
		logic            load_in;
		logic            shift_exp;
		logic            emit;
		jcond_t          cond;
		logic            hold;
		logic [PC_W-1:0] target;
	} ctl_t;

	localparam ctl_t CTL_NOP = '{
		mul_en: 1'b0, op: OP_SQUARE, x_en: 1'b0, add_lo: 1'b0, sub_en: 1'b0,
		fix_en: 1'b0, dst: DST_ACC, load_in: 1'b0, shift_exp: 1'b0, emit: 1'b0,
		cond: JC_NEVER, hold: 1'b0, target: PC_WAIT
	};

	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t c;
		c = CTL_NOP;
		case (pc)
			PC_WAIT: begin
				c.load_in = 1'b1;
				c.cond    = JC_INPUT;
				c.hold    = 1'b1;
				c.target  = PC_BASE_MUL;
			end
			PC_BASE_MUL: begin
				c.mul_en = 1'b1;
				c.op     = OP_BASE_HI;
			end
			PC_SQ_MUL: begin
				c.mul_en = 1'b1;
				c.op     = OP_SQUARE;
			end
			PC_MB_MUL: begin
				c.mul_en = 1'b1;
				c.op     = OP_MUL_BASE;
			end
			PC_BASE_EST: begin
				c.mul_en = 1'b1;
				c.op     = OP_ESTIMATE;
				c.x_en   = 1'b1;
				c.add_lo = 1'b1;
			end
			PC_SQ_EST, PC_MB_EST: begin
				c.mul_en = 1'b1;
				c.op     = OP_ESTIMATE;
				c.x_en   = 1'b1;
			end
			PC_BASE_QP, PC_SQ_QP, PC_MB_QP: begin
				c.mul_en = 1'b1;
				c.op     = OP_QUOT;
			end
			PC_BASE_SUB, PC_SQ_SUB, PC_MB_SUB: begin
				c.sub_en = 1'b1;
			end
			PC_BASE_FIX: begin
				c.fix_en = 1'b1;
				c.dst    = DST_BASE;
			end
			PC_SQ_FIX: begin
				c.fix_en = 1'b1;
				c.dst    = DST_ACC;
				c.cond   = JC_BIT_CLEAR;
				c.target = PC_NEXT;
			end
			PC_MB_FIX: begin
				c.fix_en = 1'b1;
				c.dst    = DST_ACC;
			end
			PC_NEXT: begin
				c.shift_exp = 1'b1;
				c.cond      = JC_MORE_BITS;
				c.target    = PC_SQ_MUL;
			end
			PC_FINAL: begin
				c.emit   = 1'b1;
				c.cond   = JC_OUT_FREE;
				c.hold   = 1'b1;
				c.target = PC_WAIT;
			end
			default: begin
				c.target = PC_WAIT;
				c.cond   = JC_OUT_FREE;
				c.hold   = 1'b0;
			end
		endcase
		return c;
	endfunction

endpackage

@@ hdl/modular_exponentiation_core.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_core: base to the power of exponent, modulo 1000000007.
// A microcoded sequencer runs square-and-multiply over the exponent bits on one
// shared 32x32 multiplier with a Barrett reduction after every product.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Each modular product runs through the
// steps product, quotient estimate, quotient times prime, subtract and
// correction, the first three on the shared multiplier; the base is reduced by
// one such product first. A multiply by the base follows the squaring only for
// set bits among the low EXP_BITS exponent bits, by default 63. The next input
// is accepted as soon as the result is in the output register.
module modular_exponentiation_core #(
	parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [62:0] base,
	input  logic [62:0] exponent,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [29:0] power_mod
);

	localparam int CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

	logic [modexp_pkg::PC_W-1:0] pc_q;
	logic [modexp_pkg::PC_W-1:0] pc_d;
	modexp_pkg::ctl_t            ctl;
	logic                        jump;

	logic [CNT_W-1:0]    cnt_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [30:0]         bh_q;
	logic [31:0]         bl_q;
	logic [29:0]         base_q;
	logic [29:0]         acc_q;
	logic [63:0]         prod_q;
	logic [60:0]         x_q;
	logic [32:0]         r_q;
	logic                out_valid_q;
	logic [29:0]         power_mod_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [32:0] fixed;

	assign ctl      = modexp_pkg::ucode(pc_q);
	assign in_stall = (pc_q != modexp_pkg::PC_WAIT);

	always_comb begin
		case (ctl.cond)
			modexp_pkg::JC_INPUT:     jump = in_valid;
			modexp_pkg::JC_BIT_CLEAR: jump = !exp_q[EXP_BITS-1];
			modexp_pkg::JC_MORE_BITS: jump = (cnt_q != '0);
			modexp_pkg::JC_OUT_FREE:  jump = !(out_valid_q && out_stall);
			default:                  jump = 1'b0;
		endcase
		if (jump) begin
			pc_d = ctl.target;
		end else if (ctl.hold) begin
			pc_d = pc_q;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	always_comb begin
		case (ctl.op)
			modexp_pkg::OP_BASE_HI: begin
				mul_a = {1'b0, bh_q};
				mul_b = modexp_pkg::R32;
			end
			modexp_pkg::OP_SQUARE: begin
				mul_a = {2'b00, acc_q};
				mul_b = {2'b00, acc_q};
			end
			modexp_pkg::OP_MUL_BASE: begin
				mul_a = {2'b00, acc_q};
				mul_b = {2'b00, base_q};
			end
			modexp_pkg::OP_ESTIMATE: begin
				mul_a = prod_q[60:29];
				mul_b = modexp_pkg::BARRETT_M;
			end
			modexp_pkg::OP_QUOT: begin
				mul_a = prod_q[63:32];
				mul_b = modexp_pkg::PRIME;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	always_comb begin
		if (r_q >= modexp_pkg::PRIME_X6) begin
			fixed = r_q - modexp_pkg::PRIME_X6;
		end else if (r_q >= modexp_pkg::PRIME_X5) begin
			fixed = r_q - modexp_pkg::PRIME_X5;
		end else if (r_q >= modexp_pkg::PRIME_X4) begin
			fixed = r_q - modexp_pkg::PRIME_X4;
		end else if (r_q >= modexp_pkg::PRIME_X3) begin
			fixed = r_q - modexp_pkg::PRIME_X3;
		end else if (r_q >= modexp_pkg::PRIME_X2) begin
			fixed = r_q - modexp_pkg::PRIME_X2;
		end else if (r_q >= modexp_pkg::PRIME_X1) begin
			fixed = r_q - modexp_pkg::PRIME_X1;
		end else begin
			fixed = r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= modexp_pkg::PC_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (ctl.emit && jump) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in && in_valid) begin
			bh_q  <= base[62:32];
			bl_q  <= base[31:0];
			exp_q <= exponent[EXP_BITS-1:0];
			cnt_q <= CNT_W'(EXP_BITS - 1);
			acc_q <= 30'd1;
		end
		if (ctl.mul_en) begin
			prod_q <= mul_p;
		end
		if (ctl.x_en) begin
			x_q <= {1'b0, prod_q[59:0]} + (ctl.add_lo ? {29'd0, bl_q} : 61'd0);
		end
		if (ctl.sub_en) begin
			r_q <= x_q[32:0] - prod_q[32:0];
		end
		if (ctl.fix_en) begin
			if (ctl.dst == modexp_pkg::DST_BASE) begin
				base_q <= fixed[29:0];
			end else begin
				acc_q <= fixed[29:0];
			end
		end
		if (ctl.shift_exp) begin
			exp_q <= exp_q << 1;
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
		if (ctl.emit && jump) begin
			power_mod_q <= acc_q;
		end
	end

	assign out_valid = out_valid_q;
	assign power_mod = power_mod_q;

endmodule

@@ hdl/modexp_checker.sv @@
// ----------------------------------------------------------------------------
// modexp_checker: port-level checks for the modular exponentiation core.
// Watches the two channels of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
module modexp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [29:0] power_mod
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Result withdrawn while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(power_mod))
		else $error("Stalled result changed.");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (power_mod < 30'(modexp_pkg::PRIME)))
		else $error("Result is not reduced modulo the prime.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !(out_valid && !$past(out_valid)))
		else $error("Core took a new transaction or produced a result too early.");

endmodule

bind modular_exponentiation_core modexp_checker u_modexp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.power_mod (power_mod)
);

@@ test/modular_exponentiation_core_tb.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_core_tb: self-checking bench for the modular power core.
// Drives base and exponent transactions: a directed set of edge operands first,
// then random operands under three idling patterns. A scoreboard predicts
// base^exponent mod 1000000007 for each accepted input and checks every result.
// ----------------------------------------------------------------------------
module modular_exponentiation_core_tb;

	localparam logic [63:0] MODULUS = 64'd1000000007;
	localparam int RANDOM_ITEMS = 650;

	class powmod_scoreboard;
		logic [29:0] pending_powers[$];
		logic [62:0] pending_bases[$];
		logic [62:0] pending_exponents[$];
		int failures;
		int inputs_seen;
		int results_checked;

		function new();
			failures = 0;
			inputs_seen = 0;
			results_checked = 0;
		endfunction

		function logic [29:0] predict_power_mod(logic [62:0] b, logic [62:0] e);
			logic [63:0] reduced;
			logic [63:0] acc;
			reduced = {1'b0, b} % MODULUS;
			acc = 64'd1;
			for (int i = 62; i >= 0; i--) begin
				acc = (acc * acc) % MODULUS;
				if (e[i])
					acc = (acc * reduced) % MODULUS;
			end
			return acc[29:0];
		endfunction

		function void note_input(logic [62:0] b, logic [62:0] e);
			pending_powers.push_back(predict_power_mod(b, e));
			pending_bases.push_back(b);
			pending_exponents.push_back(e);
			inputs_seen++;
		endfunction

		function void check_result(logic [29:0] got);
			logic [29:0] want;
			logic [62:0] b;
			logic [62:0] e;
			if (pending_powers.size() == 0) begin
				$display("%0t: unexpected result power_mod=%0d", $time, got);
				failures++;
				return;
			end
			want = pending_powers.pop_front();
			b = pending_bases.pop_front();
			e = pending_exponents.pop_front();
			results_checked++;
			if (got !== want) begin
				$display("%0t: power_mod mismatch for base=%0d exponent=%0d: expected %0d, got %0d",
					$time, b, e, want, got);
				failures++;
			end
		endfunction

		function int outstanding();
			return pending_powers.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [62:0] base;
	logic [62:0] exponent;
	logic        out_valid;
	logic        out_stall;
	logic [29:0] power_mod;

	int gap_pct;
	int stall_pct;

	powmod_scoreboard tracker = new();

	modular_exponentiation_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.base      (base),
		.exponent  (exponent),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.power_mod (power_mod)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [62:0] rand63();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[62:0];
	endfunction

	task automatic send_item(input logic [62:0] b, input logic [62:0] e);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			base = rand63();
			exponent = rand63();
			@(negedge clk);
		end
		in_valid = 1'b1;
		base = b;
		exponent = e;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		tracker.note_input(b, e);
	endtask

	task automatic send_random_item();
		logic [63:0] k;
		logic [62:0] b;
		logic [62:0] e;
		b = rand63();
		e = rand63();
		case ($urandom_range(9))
			4: b = 63'($urandom_range(32'h7FFF_FFFF));
			5: begin
				k = 64'({$urandom_range(1), $urandom});
				b = 63'(k * MODULUS + 64'($urandom_range(2)) - 64'd1);
			end
			6: e = 63'($urandom_range(64));
			7: begin
				case ($urandom_range(4))
					0: e = '1;
					1: e = 63'd1 << $urandom_range(62);
					2: e = 63'(MODULUS - 64'd1);
					3: e = 63'(MODULUS - 64'd2);
					default: e = '0;
				endcase
			end
			8: begin
				case ($urandom_range(3))
					0: b = '0;
					1: b = 63'd1;
					2: b = 63'(MODULUS - 64'd1);
					default: b = 63'(MODULUS);
				endcase
			end
			9: begin
				if ($urandom_range(1))
					e = rand63() & rand63() & rand63();
				else
					e = rand63() | rand63() | rand63();
			end
			default: ;
		endcase
		send_item(b, e);
	endtask

	always @(negedge clk) begin
		if (arst_n)
			out_stall = ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			tracker.check_result(power_mod);
	end

	initial begin
		#40000000;
		$display("modular_exponentiation_core_tb NOT OK");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		base = '0;
		exponent = '0;
		out_stall = 1'b0;
		arst_n = 1'b0;
		gap_pct = 28;
		stall_pct = 48;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		send_item('0, '0);
		send_item('0, 63'd5);
		send_item('0, '1);
		send_item(63'd1, '1);
		send_item('1, '0);
		send_item('1, '1);
		send_item('1, 63'd1);
		send_item(63'(MODULUS), 63'd3);
		send_item(63'(MODULUS - 64'd1), 63'd2);
		send_item(63'(MODULUS - 64'd1), 63'd3);
		send_item(63'(MODULUS + 64'd1), '1);
		send_item(63'd2, 63'd1 << 62);
		send_item(63'd1 << 62, 63'd2);
		send_item(63'd3, 63'(MODULUS - 64'd1));
		send_item(63'd12345, 63'(MODULUS - 64'd2));
		send_item(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
		send_item(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
		send_item(63'd2, 63'd62);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					gap_pct = 28;
					stall_pct = 48;
				end
				1: begin
					gap_pct = 48;
					stall_pct = 28;
				end
				default: begin
					gap_pct = 0;
					stall_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 3 + (phase == 2 ? RANDOM_ITEMS % 3 : 0); n++)
				send_random_item();
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (800) @(posedge clk);

		$display("Sent %0d transactions (edge operands, then random operands under three idling patterns).",
			tracker.inputs_seen);
		$display("Checked %0d results, %0d mismatches.", tracker.results_checked, tracker.failures);
		if (tracker.failures == 0)
			$display("modular_exponentiation_core_tb OK");
		else
			$display("modular_exponentiation_core_tb NOT OK");
		$finish;
	end

endmodule
